// ===== design/ncp_pkg.sv =====
// shared types, constants and reset image for the nibble serial clock port
package ncp_pkg;

  localparam int unsigned PortW = 4;
  localparam int unsigned DataW = 8;
  localparam int unsigned NibW  = 4;
  localparam int unsigned ClockDepth = 16;
  localparam int unsigned LatchDepth = 4;

  localparam logic [PortW-1:0] CLOCK_PORT   = 4'hA;
  localparam logic [1:0]       LATCH_GROUP  = 2'b01;
  localparam logic [DataW-1:0] DISPLAY_CODE = 8'h10;
  localparam logic [DataW-1:0] BATTERY_CODE = 8'h88;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } command_t;

  typedef enum logic [2:0] {
    PH_SELECT = 3'b001,
    PH_HIGH   = 3'b010,
    PH_LOW    = 3'b100
  } phase_t;

  typedef struct packed {
    logic            wr;
    logic            rd;
    logic [NibW-1:0] nibble;
  } clock_req_t;

  function automatic logic [DataW-1:0] clock_reset_byte(input logic [PortW-1:0] idx);
    logic [DataW-1:0] val;
    val = '0;
    unique case (idx)
      4'h3, 4'h4, 4'hF: val = 8'h01;
      4'h5:             val = BATTERY_CODE;
      4'hB, 4'hD:       val = DISPLAY_CODE;
      default:          val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== design/ncp_clock.sv =====
// clock memory with shared transfer phase counter and entry select
module ncp_clock (
  input  logic                     clk,
  input  logic                     rst,
  input  ncp_pkg::clock_req_t      req,
  output logic [ncp_pkg::DataW-1:0] rd_data
);
  import ncp_pkg::*;

  logic [DataW-1:0] mem [ClockDepth];
  phase_t           phase;
  phase_t           phase_next;
  logic [PortW-1:0] selected_entry;
  logic [DataW-1:0] cur;

  assign cur = mem[selected_entry];

  // read value and phase advance
  always_comb begin
    rd_data    = '0;
    phase_next = phase;
    if (req.wr) begin
      unique case (phase)
        PH_SELECT: phase_next = PH_HIGH;
        PH_HIGH:   phase_next = PH_LOW;
        PH_LOW:    phase_next = PH_SELECT;
        default:   phase_next = phase;
      endcase
    end else if (req.rd) begin
      unique case (phase)
        PH_SELECT: phase_next = PH_SELECT;
        PH_HIGH: begin
          rd_data    = {{(DataW-NibW){1'b0}}, cur[DataW-1:NibW]};
          phase_next = PH_LOW;
        end
        PH_LOW: begin
          rd_data    = {{(DataW-NibW){1'b0}}, cur[NibW-1:0]};
          phase_next = PH_SELECT;
        end
        default:   phase_next = phase;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SELECT;
      selected_entry <= '0;
      for (int i = 0; i < ClockDepth; i++) begin
        mem[i] <= clock_reset_byte(PortW'(i));
      end
    end else begin
      phase <= phase_next;
      if (req.wr) begin
        unique case (phase)
          PH_SELECT: selected_entry <= req.nibble;
          PH_HIGH:   mem[selected_entry][DataW-1:NibW] <= req.nibble;
          PH_LOW:    mem[selected_entry][NibW-1:0] <= req.nibble;
          default:   ;
        endcase
      end
    end
  end

endmodule

// ===== design/nibble_serial_clock_port.sv =====
// top level: bus access decode, latch bank and result register
//
// one input beat carries one bus access (command, port_offset, write_data)
// and produces exactly one output beat carrying read_data.
// writes to offsets 4 to 7 store the byte in the latch bank, reads return
// the latch, offset 10 reaches the clock memory one nibble per access
// (select, high nibble, low nibble), all other reads and every write give 0.
// the result is registered and appears in the cycle after the input beat is taken.
// throughput: one beat per cycle while the receiver takes results; decode,
// latch and clock memory update all happen in the accepting cycle, ahead
// of the single result register. when the receiver stalls, the result
// register holds its beat and in_ready drops until it is taken; a new beat
// may enter in the same cycle the old result leaves.
// reset (rst, synchronous) empties the result register, clears the latch
// bank and phase counter, and reloads the clock memory default image; the
// block accepts beats in the first cycle after reset.
module nibble_serial_clock_port (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       command,
  input  logic [ncp_pkg::PortW-1:0]  port_offset,
  input  logic [ncp_pkg::DataW-1:0]  write_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ncp_pkg::DataW-1:0]  read_data
);
  import ncp_pkg::*;

  logic             accept;
  logic             is_write;
  logic             in_latch;
  logic [DataW-1:0] latch_bytes [LatchDepth];
  logic [DataW-1:0] clock_data;
  logic [DataW-1:0] result;
  clock_req_t       creq;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_write = (command == CMD_WRITE);
  assign in_latch = (port_offset[PortW-1:2] == LATCH_GROUP);

  assign creq.wr     = accept && is_write && (port_offset == CLOCK_PORT);
  assign creq.rd     = accept && !is_write && (port_offset == CLOCK_PORT);
  assign creq.nibble = write_data[NibW-1:0];

  ncp_clock u_clock (
    .clk     (clk),
    .rst     (rst),
    .req     (creq),
    .rd_data (clock_data)
  );

  always_comb begin
    result = '0;
    if (!is_write) begin
      if (in_latch) begin
        result = latch_bytes[port_offset[1:0]];
      end else if (port_offset == CLOCK_PORT) begin
        result = clock_data;
      end
    end
  end

  // only offsets 4 to 7 are ever read back from the latch bank
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LatchDepth; i++) begin
        latch_bytes[i] <= '0;
      end
    end else if (accept && is_write && in_latch) begin
      latch_bytes[port_offset[1:0]] <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data <= result;
    end
  end

endmodule

// ===== verif/testbench.sv =====
// testbench for nibble_serial_clock_port: driven access stream checked against a scoreboard
`timescale 1ns / 100ps

module testbench;
  import ncp_pkg::*;

  class port_scoreboard;
    logic [DataW-1:0] latch_bank [16];
    logic [DataW-1:0] clock_mem [ClockDepth];
    phase_t           step;
    logic [NibW-1:0]  entry;
    logic [DataW-1:0] pending_reads [$];
    int unsigned      faults;

    function new();
      foreach (latch_bank[i]) latch_bank[i] = '0;
      foreach (clock_mem[i]) clock_mem[i] = '0;
      clock_mem[3]  = 8'h01;
      clock_mem[4]  = 8'h01;
      clock_mem[15] = 8'h01;
      clock_mem[5]  = BATTERY_CODE;
      clock_mem[11] = DISPLAY_CODE;
      clock_mem[13] = DISPLAY_CODE;
      step   = PH_SELECT;
      entry  = '0;
      faults = 0;
    endfunction

    function void note_access(command_t cmd, logic [PortW-1:0] port, logic [DataW-1:0] data);
      logic [DataW-1:0] value;
      value = '0;
      if (cmd == CMD_WRITE) begin
        latch_bank[port] = data;
        if (port == CLOCK_PORT) begin
          case (step)
            PH_SELECT: begin
              entry = data[NibW-1:0];
              step  = PH_HIGH;
            end
            PH_HIGH: begin
              clock_mem[entry][7:4] = data[NibW-1:0];
              step = PH_LOW;
            end
            PH_LOW: begin
              clock_mem[entry][3:0] = data[NibW-1:0];
              step = PH_SELECT;
            end
            default: ;
          endcase
        end
      end else if (port[3:2] == LATCH_GROUP) begin
        value = latch_bank[port];
      end else if (port == CLOCK_PORT) begin
        case (step)
          PH_HIGH: begin
            value = {4'h0, clock_mem[entry][7:4]};
            step  = PH_LOW;
          end
          PH_LOW: begin
            value = {4'h0, clock_mem[entry][3:0]};
            step  = PH_SELECT;
          end
          default: value = '0;
        endcase
      end
      pending_reads.push_back(value);
    endfunction

    function void check_read(logic [DataW-1:0] actual);
      logic [DataW-1:0] want;
      if (pending_reads.size() == 0) begin
        faults++;
        if (faults <= 10) $display("unexpected result beat: read_data %02h", actual);
      end else begin
        want = pending_reads.pop_front();
        if (actual !== want) begin
          faults++;
          if (faults <= 10)
            $display("read_data mismatch: expected %02h, got %02h", want, actual);
        end
      end
    endfunction
  endclass

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned RandomBeats = 450;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             command = 1'b0;
  logic [PortW-1:0] port_offset = '0;
  logic [DataW-1:0] write_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [DataW-1:0] read_data;

  port_scoreboard sb = new();
  bit             steady = 1'b0;
  bit             hold_request = 1'b0;
  int unsigned    beats_sent = 0;
  int unsigned    quiet_cycles = 0;

  nibble_serial_clock_port dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .port_offset (port_offset),
    .write_data  (write_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_data   (read_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_access(command_t'(command), port_offset, write_data);
      if (out_valid && out_ready) sb.check_read(read_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 23);
        @(posedge clk);
      end
    end
  end

  task automatic send_access(command_t cmd, logic [PortW-1:0] port, logic [DataW-1:0] data);
    while (!steady && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    port_offset <= port;
    write_data  <= data;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic send_clock_op();
    send_access(command_t'($urandom_range(1)), CLOCK_PORT, DataW'($urandom_range(255)));
  endtask

  // the beat accepted at the current edge may not be noted yet
  task automatic wait_for_drain();
    do @(posedge clk); while (sb.pending_reads.size() != 0);
  endtask

  initial begin
    int unsigned kind;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // latch bank and unused ports
    send_access(CMD_READ,  4'h0, 8'hFF);
    send_access(CMD_READ,  4'h4, 8'h00);
    send_access(CMD_WRITE, 4'h4, 8'hFF);
    send_access(CMD_WRITE, 4'h5, 8'h00);
    send_access(CMD_WRITE, 4'h7, 8'hA5);
    send_access(CMD_WRITE, 4'h0, 8'h5A);
    send_access(CMD_WRITE, 4'hF, 8'hFF);
    send_access(CMD_READ,  4'h4, 8'h00);
    send_access(CMD_READ,  4'h5, 8'h00);
    send_access(CMD_READ,  4'h7, 8'h00);
    send_access(CMD_READ,  4'h0, 8'h00);
    send_access(CMD_READ,  4'hF, 8'h00);
    // clock read in select phase, then reset image entries
    send_access(CMD_READ,  CLOCK_PORT, 8'h00);
    send_access(CMD_WRITE, CLOCK_PORT, 8'hF3);
    send_access(CMD_READ,  CLOCK_PORT, 8'h00);
    send_access(CMD_READ,  CLOCK_PORT, 8'h00);
    send_access(CMD_WRITE, CLOCK_PORT, 8'h0B);
    send_access(CMD_READ,  CLOCK_PORT, 8'h00);
    send_access(CMD_READ,  CLOCK_PORT, 8'h00);
    // clock write of both nibbles, read back, latch copy of port 10 unseen
    send_access(CMD_WRITE, CLOCK_PORT, 8'h05);
    send_access(CMD_WRITE, CLOCK_PORT, 8'hFC);
    send_access(CMD_WRITE, CLOCK_PORT, 8'h07);
    send_access(CMD_WRITE, CLOCK_PORT, 8'h05);
    send_access(CMD_READ,  CLOCK_PORT, 8'h00);
    send_access(CMD_READ,  CLOCK_PORT, 8'h00);

    for (int unsigned n = 0; n < RandomBeats; ) begin
      steady = (n >= 50 && n < 130);
      if (n >= 150 && n < 153) hold_request = 1'b1;
      if (n >= 300 && n < 303) begin
        in_valid <= 1'b0;
        wait_for_drain();
        n += 3;
      end
      kind = $urandom_range(9);
      if (kind < 5) begin
        send_access(CMD_WRITE, CLOCK_PORT, DataW'($urandom_range(255)));
        send_clock_op();
        send_clock_op();
        n += 3;
      end else if (kind < 8) begin
        send_access(command_t'($urandom_range(1)), PortW'(4 + $urandom_range(3)),
                    DataW'($urandom_range(255)));
        n++;
      end else begin
        send_access(command_t'($urandom_range(1)), PortW'($urandom_range(15)),
                    DataW'($urandom_range(255)));
        n++;
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    wait_for_drain();
    repeat (10) @(posedge clk);
    if (sb.pending_reads.size() != 0) begin
      $display("%0d expected results never arrived", sb.pending_reads.size());
      sb.faults++;
    end
    if (sb.faults == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
